/* rtl/core/ogru_pkg.sv */
// Shared types and constants for the occupancy grid ray update core.
// No dependencies.
package ogru_pkg;

    typedef enum logic [1:0] {
        FUNC_HIT  = 2'd0,
        FUNC_RAY  = 2'd1,
        FUNC_EOS  = 2'd2,
        FUNC_READ = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_MAX_RANGE = 2'd0,
        CFG_HIT_ODDS  = 2'd1,
        CFG_MISS_ODDS = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_FINISH,
        S_RESP
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic decode;
        logic walk;
        logic set_scan;
    } t_cmd;

    typedef struct packed {
        logic  clear_done;
        t_func func;
        logic  active;
        logic  walk_done;
    } t_sts;

    localparam logic [15:0] MAX_RANGE_RST = 16'hFFFF;
    localparam logic [6:0]  HIT_ODDS_RST  = 7'd3;
    localparam logic [6:0]  MISS_ODDS_RST = 7'd1;

endpackage

/* rtl/core/ogru_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ogru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/ogru_ctrl.sv */
// Controller state machine: clearing pass, item decode, ray walk and result handshake.
// Depends on ogru_pkg.
module ogru_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  ogru_pkg::t_sts i_sts,
    output ogru_pkg::t_cmd o_cmd
);
    import ogru_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                unique case (i_sts.func) inside
                    FUNC_RAY: begin
                        n_state = i_sts.active ? S_WALK : S_RESP;
                    end
                    FUNC_EOS: begin
                        o_cmd.set_scan = 1'b1;
                        n_state        = S_RESP;
                    end
                    FUNC_HIT, FUNC_READ: begin
                        n_state = S_FINISH;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_RESP;
                end
            end
            S_FINISH: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end
endmodule

/* rtl/core/ogru_dp.sv */
// Datapath: configuration registers, item registers, Bresenham stepper,
// saturating read-modify-write stage and the grid memory. Depends on ogru_pkg, ogru_ram.
module ogru_dp #(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic [1:0]         i_func,
    input  logic [15:0]        i_range_mm,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_end_x,
    input  logic signed [15:0] i_end_y,
    input  ogru_pkg::t_cmd     i_cmd,
    output ogru_pkg::t_sts     o_sts,
    output logic signed [7:0]  o_cell_odds,
    output logic [15:0]        o_cells_updated
);
    import ogru_pkg::*;

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);

    logic [15:0]        r_max_range;
    logic [6:0]         r_hit_odds;
    logic [6:0]         r_miss_odds;
    logic               r_scan_seen;
    t_func              r_func;
    logic [15:0]        r_range;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_ex;
    logic signed [15:0] r_ey;
    logic [16:0]        r_dx;
    logic [16:0]        r_dy;
    logic               r_stx;
    logic               r_sty;
    logic signed [19:0] r_err;
    logic [AW-1:0]      r_clr_addr;
    logic               r_wb_valid;
    logic               r_wb_neg;
    logic [AW-1:0]      r_wb_addr;
    logic               r_rd_pend;
    logic signed [7:0]  r_odds;
    logic [15:0]        r_cnt;

    logic signed [16:0] w_ddx;
    logic signed [16:0] w_ddy;
    logic signed [15:0] w_ax;
    logic signed [15:0] w_ay;
    logic               w_a_in;
    logic [AW-1:0]      w_addr;
    logic               w_walk_done;
    logic               w_step;
    logic               w_active;
    logic signed [20:0] w_e2;
    logic signed [20:0] w_dx21;
    logic signed [20:0] w_dy21;
    logic               w_cx;
    logic               w_cy;
    logic [7:0]         w_rdata;
    logic signed [9:0]  w_old;
    logic signed [9:0]  w_delta;
    logic signed [9:0]  w_sum;
    logic signed [7:0]  w_sat;
    logic               w_changed;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [7:0]         w_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range <= MAX_RANGE_RST;
            r_hit_odds  <= HIT_ODDS_RST;
            r_miss_odds <= MISS_ODDS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_RANGE: r_max_range <= i_cfg_data;
                CFG_HIT_ODDS:  r_hit_odds  <= i_cfg_data[6:0];
                CFG_MISS_ODDS: r_miss_odds <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    assign w_ddx = 17'(i_end_x) - 17'(i_start_x);
    assign w_ddy = 17'(i_end_y) - 17'(i_start_y);

    assign w_active    = r_scan_seen && (r_range <= r_max_range);
    assign w_walk_done = (r_x == r_ex) && (r_y == r_ey);
    assign w_step      = i_cmd.walk && !w_walk_done;

    assign w_ax   = (i_cmd.decode && r_func == FUNC_HIT) ? r_ex : r_x;
    assign w_ay   = (i_cmd.decode && r_func == FUNC_HIT) ? r_ey : r_y;
    assign w_a_in = !w_ax[15] && (w_ax[14:0] < 15'(GRID_WIDTH))
                 && !w_ay[15] && (w_ay[14:0] < 15'(GRID_HEIGHT));
    assign w_addr = AW'(w_ay[YW-1:0]) * AW'(GRID_WIDTH) + AW'(w_ax[XW-1:0]);

    assign w_e2   = {r_err, 1'b0};
    assign w_dx21 = $signed(21'(r_dx));
    assign w_dy21 = $signed(21'(r_dy));
    assign w_cx   = w_e2 >= -w_dy21;
    assign w_cy   = w_e2 <= w_dx21;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= t_func'(i_func);
            r_range <= i_range_mm;
            r_x     <= i_start_x;
            r_y     <= i_start_y;
            r_ex    <= i_end_x;
            r_ey    <= i_end_y;
            r_dx    <= w_ddx[16] ? 17'(-w_ddx) : 17'(w_ddx);
            r_dy    <= w_ddy[16] ? 17'(-w_ddy) : 17'(w_ddy);
            r_stx   <= i_start_x < i_end_x;
            r_sty   <= i_start_y < i_end_y;
        end else if (w_step) begin
            if (w_cx) begin
                r_x <= r_stx ? r_x + 16'sd1 : r_x - 16'sd1;
            end
            if (w_cy) begin
                r_y <= r_sty ? r_y + 16'sd1 : r_y - 16'sd1;
            end
        end
        if (i_cmd.decode) begin
            r_err <= $signed(20'(r_dx)) - $signed(20'(r_dy));
        end else if (w_step) begin
            r_err <= r_err - (w_cx ? $signed(20'(r_dy)) : 20'sd0)
                           + (w_cy ? $signed(20'(r_dx)) : 20'sd0);
        end
        r_wb_addr <= w_addr;
        r_wb_neg  <= i_cmd.walk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_seen <= 1'b0;
            r_clr_addr  <= '0;
            r_wb_valid  <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_odds      <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cmd.set_scan) begin
                r_scan_seen <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_wb_valid <= w_a_in && ((i_cmd.decode && r_func == FUNC_HIT && w_active)
                                     || w_step);
            r_rd_pend  <= w_a_in && i_cmd.decode && r_func == FUNC_READ;
            if (i_cmd.load) begin
                r_odds <= '0;
                r_cnt  <= '0;
            end else begin
                if (r_rd_pend) begin
                    r_odds <= $signed(w_rdata);
                end
                if (r_wb_valid && w_changed && r_cnt != 16'hFFFF) begin
                    r_cnt <= r_cnt + 16'd1;
                end
            end
        end
    end

    assign w_old   = 10'($signed(w_rdata));
    assign w_delta = r_wb_neg ? -$signed({3'b000, r_miss_odds})
                              : $signed({3'b000, r_hit_odds});
    assign w_sum   = w_old + w_delta;
    assign w_sat   = (w_sum > 10'sd127)  ? 8'sd127 :
                     (w_sum < -10'sd128) ? -8'sd128 : w_sum[7:0];
    assign w_changed = w_sat != $signed(w_rdata);

    assign w_we    = i_cmd.clear || r_wb_valid;
    assign w_waddr = i_cmd.clear ? r_clr_addr : r_wb_addr;
    assign w_wdata = i_cmd.clear ? 8'd0 : w_sat;

    ogru_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign o_sts.clear_done = r_clr_addr == AW'(DEPTH - 1);
    assign o_sts.func       = r_func;
    assign o_sts.active     = w_active;
    assign o_sts.walk_done  = w_walk_done;

    assign o_cell_odds     = r_odds;
    assign o_cells_updated = r_cnt;
endmodule

/* rtl/core/occupancy_grid_ray_update_core.sv */
// Occupancy grid log-odds update core: one item at a time, next item taken the cycle after
// the result is taken. Results show in the response state, reached via decode for end of
// scan and skipped rays, via decode and a finish state for hit and read items, and via
// decode and the walk state for a ray (one cell per cycle through the grid memory
// read-modify-write). After reset a clearing pass zeroes every cell while o_ready is low.
// Depends on ogru_pkg, ogru_ctrl, ogru_dp.
module occupancy_grid_ray_update_core #(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [15:0]        i_range_mm,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_end_x,
    input  logic signed [15:0] i_end_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [7:0]  o_cell_odds,
    output logic [15:0]        o_cells_updated
);
    import ogru_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ogru_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ogru_dp #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_range_mm      (i_range_mm),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_cell_odds     (o_cell_odds),
        .o_cells_updated (o_cells_updated)
    );
endmodule

/* rtl/core/ogru_chk.sv */
// Port-level checker for the occupancy grid ray update core, bound to the top level.
// Depends on ogru_pkg and occupancy_grid_ray_update_core.
module ogru_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic [1:0]        i_func,
    input logic              o_valid,
    input logic              i_ready,
    input logic signed [7:0] o_cell_odds,
    input logic [15:0]       o_cells_updated
);
    import ogru_pkg::*;

    logic [1:0] r_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func <= FUNC_HIT;
        end else if (i_valid && o_ready) begin
            r_func <= i_func;
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input taken while a result is pending");

    a_no_same_cycle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_valid)
        else $error("result shown the cycle after accept");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_cell_odds)
                                   && $stable(o_cells_updated)))
        else $error("stalled result changed");

    a_odds_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_func != FUNC_READ) |-> (o_cell_odds == 8'sd0))
        else $error("non-zero odds on a non-read item");

    a_no_count_read_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_func == FUNC_READ || r_func == FUNC_EOS)) |-> (o_cells_updated == 16'd0))
        else $error("cells counted on a read or end-of-scan item");
endmodule

bind occupancy_grid_ray_update_core ogru_chk u_chk (.*);

/* tb/tb_occupancy_grid_ray_update_core.sv */
// Self-checking testbench for occupancy_grid_ray_update_core: directed rows, then random
// hit, ray, end-of-scan and read items under several register settings, checked per item.
// Depends on ogru_pkg and the core RTL; nothing else.
module tb_occupancy_grid_ray_update_core;
    import ogru_pkg::*;

    localparam int GRID_W      = 256;
    localparam int GRID_H      = 256;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int RX_HOLD     = 300;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        t_func              func;
        logic [15:0]        range_mm;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } t_grid_item;

    typedef struct {
        int                 seq;
        logic signed [7:0]  cell_odds;
        logic [15:0]        cells_updated;
    } t_grid_result;

    typedef struct {
        bit                 reload;
        t_func              func;
        logic [15:0]        range_mm;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        bit                 typed;
        logic signed [7:0]  cell_odds;
        logic [15:0]        cells_updated;
    } t_probe_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_func;
    logic [15:0]        i_range_mm;
    logic signed [15:0] i_start_x;
    logic signed [15:0] i_start_y;
    logic signed [15:0] i_end_x;
    logic signed [15:0] i_end_y;
    logic               o_valid;
    logic               i_ready;
    logic signed [7:0]  o_cell_odds;
    logic [15:0]        o_cells_updated;

    logic signed [7:0]  odds_map [GRID_W*GRID_H];
    bit                 scan_open;
    logic [15:0]        max_range_q;
    logic [6:0]         hit_odds_q;
    logic [6:0]         miss_odds_q;

    t_grid_result       replies_due [$];
    int                 mism_count;
    int                 replies_seen;
    int                 items_sent;
    int                 items_by_func [4];
    int                 cells_changed_total;
    int                 cycle_count;
    bit                 calm;
    bit                 rx_hold_req;

    t_probe_row probe_rows [27] = '{
        '{0, FUNC_READ, 0,     0,      0,      0,      0,     1, 0,    0},
        '{0, FUNC_HIT,  0,     32767,  -32768, 5,      5,     1, 0,    0},
        '{0, FUNC_RAY,  100,   0,      0,      10,     0,     1, 0,    0},
        '{0, FUNC_EOS,  65535, -1,     -1,     -1,     -1,    1, 0,    0},
        '{0, FUNC_HIT,  65535, -32768, 32767,  5,      5,     1, 0,    1},
        '{0, FUNC_READ, 0,     5,      5,      -32768, 32767, 1, 3,    0},
        '{0, FUNC_RAY,  0,     0,      5,      10,     5,     1, 0,    10},
        '{0, FUNC_READ, 65535, 5,      5,      0,      0,     1, 2,    0},
        '{0, FUNC_RAY,  7,     7,      7,      7,      7,     1, 0,    0},
        '{0, FUNC_HIT,  1,     0,      0,      256,    0,     1, 0,    0},
        '{0, FUNC_HIT,  2,     0,      0,      -1,     300,   1, 0,    0},
        '{0, FUNC_READ, 0,     -32768, 32767,  32767,  -1,    1, 0,    0},
        '{0, FUNC_HIT,  3,     0,      0,      255,    255,   1, 0,    1},
        '{0, FUNC_RAY,  4,     -5,     2,      5,      2,     1, 0,    5},
        '{0, FUNC_RAY,  5,     20,     20,     23,     40,    0, 0,    0},
        '{0, FUNC_RAY,  6,     32767,  32767,  -32768, -32768, 0, 0,   0},
        '{0, FUNC_READ, 0,     0,      0,      0,      0,     0, 0,    0},
        '{1, FUNC_HIT,  1001,  0,      0,      5,      5,     1, 0,    0},
        '{0, FUNC_HIT,  1000,  0,      0,      5,      5,     1, 0,    1},
        '{0, FUNC_READ, 0,     5,      5,      0,      0,     1, 127,  0},
        '{0, FUNC_HIT,  0,     0,      0,      5,      5,     1, 0,    0},
        '{0, FUNC_RAY,  1001,  5,      5,      6,      5,     1, 0,    0},
        '{0, FUNC_RAY,  5,     5,      5,      6,      5,     1, 0,    1},
        '{0, FUNC_RAY,  5,     5,      5,      6,      5,     1, 0,    1},
        '{0, FUNC_RAY,  5,     5,      5,      6,      5,     1, 0,    1},
        '{0, FUNC_RAY,  5,     5,      5,      6,      5,     1, 0,    0},
        '{0, FUNC_READ, 0,     5,      5,      0,      0,     1, -128, 0}
    };

    int phase_regs [PHASES][3] = '{
        '{65535, 3,   1},
        '{65535, 127, 127},
        '{0,     1,   0},
        '{-1,    0,   127},
        '{-1,    -1,  -1},
        '{65535, 127, 1},
        '{-1,    -1,  -1},
        '{65535, -1,  -1}
    };

    occupancy_grid_ray_update_core #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_range_mm      (i_range_mm),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cell_odds     (o_cell_odds),
        .o_cells_updated (o_cells_updated)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit on_grid(input int x, input int y);
        return x >= 0 && x < GRID_W && y >= 0 && y < GRID_H;
    endfunction

    function automatic int bump_cell(input int x, input int y, input int delta);
        int idx;
        int old;
        int v;
        idx = y * GRID_W + x;
        old = int'(odds_map[idx]);
        v = old + delta;
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        odds_map[idx] = 8'(v);
        return (v != old) ? 1 : 0;
    endfunction

    function automatic t_grid_result update_grid(input t_grid_item it);
        t_grid_result r;
        int sx, sy, ex, ey, dx, dy, stx, sty, err, e2, x, y, n;
        bit live;
        r.seq = 0;
        r.cell_odds = '0;
        r.cells_updated = '0;
        sx = int'(it.start_x);
        sy = int'(it.start_y);
        ex = int'(it.end_x);
        ey = int'(it.end_y);
        live = scan_open && (it.range_mm <= max_range_q);
        case (it.func)
            FUNC_HIT: begin
                if (live && on_grid(ex, ey))
                    r.cells_updated = 16'(bump_cell(ex, ey, int'(hit_odds_q)));
            end
            FUNC_RAY: begin
                if (live) begin
                    dx = (ex > sx) ? ex - sx : sx - ex;
                    dy = (ey > sy) ? ey - sy : sy - ey;
                    stx = (sx < ex) ? 1 : -1;
                    sty = (sy < ey) ? 1 : -1;
                    err = dx - dy;
                    x = sx;
                    y = sy;
                    n = 0;
                    while (x != ex || y != ey) begin
                        if (on_grid(x, y)) begin
                            n += bump_cell(x, y, -int'(miss_odds_q));
                            if (n > 65535) n = 65535;
                        end
                        e2 = 2 * err;
                        if (e2 >= -dy) begin
                            err -= dy;
                            x += stx;
                        end
                        if (e2 <= dx) begin
                            err += dx;
                            y += sty;
                        end
                    end
                    r.cells_updated = 16'(n);
                end
            end
            FUNC_EOS: scan_open = 1'b1;
            default: begin
                if (on_grid(sx, sy))
                    r.cell_odds = odds_map[sy * GRID_W + sx];
            end
        endcase
        return r;
    endfunction

    function automatic int near_coord(input int zone);
        if (zone < 12)
            return int'($urandom_range(0, 24)) - 4;
        else if (zone < 17)
            return int'($urandom_range(0, 269)) - 7;
        else
            return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int nudge(input int base);
        int v;
        v = base + int'($urandom_range(0, 40)) - 20;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic t_grid_item random_item();
        t_grid_item it;
        int pick;
        int zone;
        pick = int'($urandom_range(0, 99));
        zone = int'($urandom_range(0, 19));
        it.func = (pick < 30) ? FUNC_HIT : (pick < 70) ? FUNC_RAY :
                  (pick < 75) ? FUNC_EOS : FUNC_READ;
        if (max_range_q == 16'hFFFF || $urandom_range(0, 6) == 0)
            it.range_mm = 16'($urandom_range(0, 65535));
        else
            it.range_mm = 16'($urandom_range(0, max_range_q));
        it.start_x = 16'($urandom_range(0, 65535));
        it.start_y = 16'($urandom_range(0, 65535));
        it.end_x   = 16'($urandom_range(0, 65535));
        it.end_y   = 16'($urandom_range(0, 65535));
        case (it.func)
            FUNC_HIT: begin
                it.end_x = 16'(near_coord(zone));
                it.end_y = 16'(near_coord(zone));
            end
            FUNC_READ: begin
                it.start_x = 16'(near_coord(zone));
                it.start_y = 16'(near_coord(zone));
            end
            FUNC_RAY: begin
                if (zone >= 17) begin
                    it.end_x = 16'(nudge(int'(it.start_x)));
                    it.end_y = 16'(nudge(int'(it.start_y)));
                end else begin
                    it.start_x = 16'(near_coord(zone));
                    it.start_y = 16'(near_coord(zone));
                    it.end_x   = 16'(near_coord(zone));
                    it.end_y   = 16'(near_coord(zone));
                end
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic offer(input t_grid_item it, input bit typed, input t_grid_result typed_res);
        int gap;
        t_grid_result want;
        gap = calm ? 0 : int'($urandom_range(0, 4));
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= it.func;
        i_range_mm <= it.range_mm;
        i_start_x  <= it.start_x;
        i_start_y  <= it.start_y;
        i_end_x    <= it.end_x;
        i_end_y    <= it.end_y;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        want = update_grid(it);
        cells_changed_total += int'(want.cells_updated);
        if (typed) begin
            want.cell_odds     = typed_res.cell_odds;
            want.cells_updated = typed_res.cells_updated;
        end
        want.seq = items_sent;
        replies_due.push_back(want);
        items_sent++;
        items_by_func[it.func]++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_MAX_RANGE: max_range_q = val;
            CFG_HIT_ODDS:  hit_odds_q  = val[6:0];
            default:       miss_odds_q = val[6:0];
        endcase
    endtask

    initial begin
        int gap;
        i_ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (RX_HOLD) @(negedge i_clk);
            end else begin
                gap = calm ? 0 : int'($urandom_range(0, 4));
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_grid_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (replies_due.size() == 0) begin
                if (mism_count < 10)
                    $display("unexpected result: odds %0d, cells updated %0d",
                             o_cell_odds, o_cells_updated);
                mism_count++;
            end else begin
                want = replies_due.pop_front();
                replies_seen++;
                if (want.cell_odds !== o_cell_odds || want.cells_updated !== o_cells_updated)
                begin
                    if (mism_count < 10)
                        $display({"item %0d: expected odds %0d updated %0d, ",
                                  "got odds %0d updated %0d"},
                                 want.seq, want.cell_odds, want.cells_updated,
                                 o_cell_odds, o_cells_updated);
                    mism_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, replies_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_grid_item   it;
        t_grid_result typed_res;
        int           reg_val;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_func      = FUNC_HIT;
        i_range_mm  = '0;
        i_start_x   = '0;
        i_start_y   = '0;
        i_end_x     = '0;
        i_end_y     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MAX_RANGE;
        i_cfg_data  = '0;
        cycle_count = 0;
        calm        = 1'b0;
        rx_hold_req = 1'b0;
        scan_open   = 1'b0;
        max_range_q = MAX_RANGE_RST;
        hit_odds_q  = HIT_ODDS_RST;
        miss_odds_q = MISS_ODDS_RST;
        typed_res   = '{0, 0, 0};
        foreach (odds_map[k]) odds_map[k] = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_rows[k]) begin
            if (probe_rows[k].reload) begin
                settle();
                write_reg(CFG_MAX_RANGE, 16'd1000);
                write_reg(CFG_HIT_ODDS, 16'd127);
                write_reg(CFG_MISS_ODDS, 16'd127);
                @(negedge i_clk);
                i_cfg_we <= 1'b0;
            end
            it.func     = probe_rows[k].func;
            it.range_mm = probe_rows[k].range_mm;
            it.start_x  = probe_rows[k].start_x;
            it.start_y  = probe_rows[k].start_y;
            it.end_x    = probe_rows[k].end_x;
            it.end_y    = probe_rows[k].end_y;
            typed_res.cell_odds     = probe_rows[k].cell_odds;
            typed_res.cells_updated = probe_rows[k].cells_updated;
            offer(it, probe_rows[k].typed, typed_res);
        end
        settle();

        for (int p = 0; p < PHASES; p++) begin
            calm = (p == 1 || p == 5);
            for (int r = 0; r < 3; r++) begin
                reg_val = phase_regs[p][r];
                if (reg_val < 0)
                    reg_val = (r == 0) ? int'($urandom_range(100, 65534))
                                       : int'($urandom_range(0, 127));
                write_reg(t_cfg_idx'(r), reg_val[15:0]);
            end
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == 0)
                    rx_hold_req = 1'b1;
                if (p == 6 && n == PHASE_ITEMS / 2)
                    settle();
                offer(random_item(), 1'b0, typed_res);
            end
            settle();
        end

        $display("run covered %0d items: %0d hits, %0d rays, %0d scan ends, %0d reads",
                 items_sent, items_by_func[FUNC_HIT], items_by_func[FUNC_RAY],
                 items_by_func[FUNC_EOS], items_by_func[FUNC_READ]);
        $display("%0d register sets, %0d cell changes, %0d results checked, %0d mismatches",
                 PHASES + 2, cells_changed_total, replies_seen, mism_count);
        if (mism_count == 0 && replies_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ogru_pkg.sv
rtl/core/ogru_ram.sv
rtl/core/ogru_ctrl.sv
rtl/core/ogru_dp.sv
rtl/core/occupancy_grid_ray_update_core.sv
rtl/core/ogru_chk.sv
tb/tb_occupancy_grid_ray_update_core.sv
